@@ rtl/drs_pkg.sv @@
package drs_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TRACK_BITS  = 16;

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int OP_W     = 2;
    localparam int FIELD_W  = 16;
    localparam int STATUS_W = 3;
    localparam int PEND_W   = 5;

    typedef logic [TRACK_BITS-1:0] t_track;
    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [STATUS_W-1:0]   t_status;
    typedef logic [OP_W-1:0]       t_op;

    localparam t_op OP_ADD     = 2'd0;
    localparam t_op OP_SERVICE = 2'd1;
    localparam int  OP_HEAD_BIT = 1;

    localparam t_status ST_SERVICED = 3'd0;
    localparam t_status ST_EMPTY    = 3'd1;
    localparam t_status ST_ACCEPTED = 3'd2;
    localparam t_status ST_FULL     = 3'd3;
    localparam t_status ST_HEAD_SET = 3'd4;

    localparam logic POLICY_SSTF  = 1'b1;
    localparam logic POLICY_RESET = POLICY_SSTF;

endpackage

@@ rtl/drs_ram.sv @@
module drs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/disk_request_scheduler_top.sv @@
// Add, set-head and empty-service items: the result goes to the result registers, then
// to the output register once that is free; the next input beat is taken after that.
// Service: one distance compare per cycle over the queue (N entries under SSTF,
// one under FCFS), then a read (S_SH_RD) and write (S_SH_WR) move per entry behind
// the pick, as the RAM has a registered read port.
// One item is in work at a time; a finished result waits in the output register.
// Synchronous active-low reset empties the queue, zeroes the head, selects SSTF.
module disk_request_scheduler_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [drs_pkg::OP_W-1:0]      i_operation,
    input  logic [drs_pkg::FIELD_W-1:0]   i_track,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [drs_pkg::STATUS_W-1:0]  o_status,
    output logic [drs_pkg::FIELD_W-1:0]   o_served_track,
    output logic [drs_pkg::FIELD_W-1:0]   o_displacement,
    output logic                          o_moving_down,
    output logic [drs_pkg::PEND_W-1:0]    o_pending,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SH_RD,
        S_SH_WR,
        S_EMIT
    } t_state;

    t_state r_state, n_state;

    logic               r_policy, n_policy;
    drs_pkg::t_cnt      r_count, n_count;
    drs_pkg::t_track    r_head, n_head;
    logic               r_down, n_down;

    drs_pkg::t_cnt      r_idx, n_idx;
    drs_pkg::t_cnt      r_lim, n_lim;
    logic               r_rd_vld, n_rd_vld;
    drs_pkg::t_cnt      r_rd_idx, n_rd_idx;
    drs_pkg::t_cnt      r_pick, n_pick;
    drs_pkg::t_cnt      r_j, n_j;
    drs_pkg::t_track    r_best, n_best;
    drs_pkg::t_track    r_served, n_served;

    drs_pkg::t_status   r_res_status, n_res_status;
    drs_pkg::t_track    r_res_track, n_res_track;
    drs_pkg::t_track    r_res_disp, n_res_disp;

    logic                         r_o_valid, n_o_valid;
    drs_pkg::t_status             r_o_status, n_o_status;
    logic [drs_pkg::FIELD_W-1:0]  r_o_track, n_o_track;
    logic [drs_pkg::FIELD_W-1:0]  r_o_disp, n_o_disp;
    logic                         r_o_down, n_o_down;
    logic [drs_pkg::PEND_W-1:0]   r_o_pend, n_o_pend;

    logic               ram_we;
    drs_pkg::t_idx      ram_waddr;
    drs_pkg::t_track    ram_wdata;
    drs_pkg::t_idx      ram_raddr;
    drs_pkg::t_track    ram_rdata;

    logic               in_beat;
    drs_pkg::t_track    in_trk;
    drs_pkg::t_track    seek_dist;
    drs_pkg::t_cnt      j_next;
    drs_pkg::t_cnt      pick_v;

    drs_ram #(
        .WIDTH (drs_pkg::TRACK_BITS),
        .DEPTH (drs_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_beat     = i_in_valid && o_in_ready;
    assign in_trk      = drs_pkg::t_track'(i_track);
    assign seek_dist   = (ram_rdata >= r_head) ? (ram_rdata - r_head) : (r_head - ram_rdata);
    assign j_next      = r_j + 1'b1;

    always_comb begin
        n_state      = r_state;
        n_policy     = r_policy;
        n_count      = r_count;
        n_head       = r_head;
        n_down       = r_down;
        n_idx        = r_idx;
        n_lim        = r_lim;
        n_rd_vld     = r_rd_vld;
        n_rd_idx     = r_rd_idx;
        n_pick       = r_pick;
        n_j          = r_j;
        n_best       = r_best;
        n_served     = r_served;
        n_res_status = r_res_status;
        n_res_track  = r_res_track;
        n_res_disp   = r_res_disp;
        n_o_valid    = r_o_valid;
        n_o_status   = r_o_status;
        n_o_track    = r_o_track;
        n_o_disp     = r_o_disp;
        n_o_down     = r_o_down;
        n_o_pend     = r_o_pend;
        ram_we       = 1'b0;
        ram_waddr    = r_count[drs_pkg::IDX_W-1:0];
        ram_wdata    = in_trk;
        ram_raddr    = r_idx[drs_pkg::IDX_W-1:0];
        pick_v       = r_pick;

        if (i_cfg_valid) begin
            n_policy = i_cfg_data;
        end

        if (r_o_valid && i_out_ready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_res_track = '0;
                    n_res_disp  = '0;
                    n_state     = S_EMIT;
                    if (i_operation[drs_pkg::OP_HEAD_BIT]) begin
                        n_head       = in_trk;
                        n_res_status = drs_pkg::ST_HEAD_SET;
                    end else if (i_operation == drs_pkg::OP_ADD) begin
                        if (r_count < drs_pkg::t_cnt'(drs_pkg::QUEUE_DEPTH)) begin
                            ram_we       = 1'b1;
                            n_count      = r_count + 1'b1;
                            n_res_status = drs_pkg::ST_ACCEPTED;
                        end else begin
                            n_res_status = drs_pkg::ST_FULL;
                        end
                    end else if (r_count == '0) begin
                        n_res_status = drs_pkg::ST_EMPTY;
                    end else begin
                        n_idx    = '0;
                        n_lim    = (r_policy == drs_pkg::POLICY_SSTF) ? r_count
                                                                      : drs_pkg::t_cnt'(1);
                        n_rd_vld = 1'b0;
                        n_state  = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_idx < r_lim) begin
                    n_idx    = r_idx + 1'b1;
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_idx;
                end else begin
                    n_rd_vld = 1'b0;
                end
                if (r_rd_vld) begin
                    if (r_rd_idx == '0 || seek_dist < r_best) begin
                        n_best   = seek_dist;
                        pick_v   = r_rd_idx;
                        n_pick   = r_rd_idx;
                        n_served = ram_rdata;
                    end
                    if (r_rd_idx == r_lim - 1'b1) begin
                        n_j     = pick_v;
                        n_state = S_SH_RD;
                    end
                end
            end
            S_SH_RD: begin
                if (j_next < r_count) begin
                    ram_raddr = j_next[drs_pkg::IDX_W-1:0];
                    n_state   = S_SH_WR;
                end else begin
                    n_count      = r_count - 1'b1;
                    n_head       = r_served;
                    n_down       = (r_served > r_head) ? 1'b0 : 1'b1;
                    n_res_status = drs_pkg::ST_SERVICED;
                    n_res_track  = r_served;
                    n_res_disp   = r_best;
                    n_state      = S_EMIT;
                end
            end
            S_SH_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_j[drs_pkg::IDX_W-1:0];
                ram_wdata = ram_rdata;
                n_j       = j_next;
                n_state   = S_SH_RD;
            end
            S_EMIT: begin
                if (!r_o_valid || i_out_ready) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_res_status;
                    n_o_track  = drs_pkg::FIELD_W'(r_res_track);
                    n_o_disp   = drs_pkg::FIELD_W'(r_res_disp);
                    n_o_down   = r_down;
                    n_o_pend   = drs_pkg::PEND_W'(r_count);
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_policy  <= drs_pkg::POLICY_RESET;
            r_count   <= '0;
            r_head    <= '0;
            r_down    <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_policy  <= n_policy;
            r_count   <= n_count;
            r_head    <= n_head;
            r_down    <= n_down;
            r_rd_vld  <= n_rd_vld;
            r_o_valid <= n_o_valid;
        end
        r_idx        <= n_idx;
        r_lim        <= n_lim;
        r_rd_idx     <= n_rd_idx;
        r_pick       <= n_pick;
        r_j          <= n_j;
        r_best       <= n_best;
        r_served     <= n_served;
        r_res_status <= n_res_status;
        r_res_track  <= n_res_track;
        r_res_disp   <= n_res_disp;
        r_o_status   <= n_o_status;
        r_o_track    <= n_o_track;
        r_o_disp     <= n_o_disp;
        r_o_down     <= n_o_down;
        r_o_pend     <= n_o_pend;
    end

    assign o_out_valid    = r_o_valid;
    assign o_status       = r_o_status;
    assign o_served_track = r_o_track;
    assign o_displacement = r_o_disp;
    assign o_moving_down  = r_o_down;
    assign o_pending      = r_o_pend;

endmodule

@@ rtl/drs_checker.sv @@
module drs_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [drs_pkg::STATUS_W-1:0]  o_status,
    input logic [drs_pkg::FIELD_W-1:0]   o_served_track,
    input logic [drs_pkg::FIELD_W-1:0]   o_displacement,
    input logic                          o_moving_down,
    input logic [drs_pkg::PEND_W-1:0]    o_pending
);

    // drop the result beat after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pending <= drs_pkg::PEND_W'(drs_pkg::QUEUE_DEPTH)))
        else $error("pending count above queue depth");

    a_idle_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != drs_pkg::ST_SERVICED)
        |-> (o_served_track == '0) && (o_displacement == '0))
        else $error("track or displacement set without service");

    a_up_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == drs_pkg::ST_SERVICED) && !o_moving_down
        |-> (o_displacement != '0))
        else $error("upward service with zero displacement");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
        && $stable(o_served_track) && $stable(o_pending))
        else $error("stalled result beat changed");

endmodule

bind disk_request_scheduler_top drs_checker u_drs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_status       (o_status),
    .o_served_track (o_served_track),
    .o_displacement (o_displacement),
    .o_moving_down  (o_moving_down),
    .o_pending      (o_pending)
);
